// ===== src/chpe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the cubic Hermite point evaluator.
// No dependencies; imported by every module of the block.
package chpe_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int T_FRAC_BITS = 16;
	localparam int PARAM_WIDTH = 32;
	localparam int CFG_IDX_W   = 4;

	// s = 1 - t needs one bit above the fraction
	localparam int T_W    = T_FRAC_BITS + 1;
	localparam int WGT_W  = T_FRAC_BITS + 2;
	localparam int WPROD_W = T_W + WGT_W;
	localparam int POS_W  = COORD_WIDTH + 1;
	localparam int PROD_W = POS_W + WGT_W + 1;
	localparam int SUM_W  = PROD_W + 2;

	localparam logic [T_W-1:0]     T_ONE   = T_W'(1) << T_FRAC_BITS;
	localparam logic [WPROD_W-1:0] W_HALF  = WPROD_W'(1) << (T_FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0] SUM_HALF = SUM_W'(1) <<< (T_FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0] SAT_MAX  = (SUM_W'(1) <<< (COORD_WIDTH - 1)) - 1;
	localparam logic signed [SUM_W-1:0] SAT_MIN  = -SAT_MAX - 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_POS_X = 4'd0,
		REG_START_POS_Y = 4'd1,
		REG_END_POS_X   = 4'd2,
		REG_END_POS_Y   = 4'd3,
		REG_START_TAN_X = 4'd4,
		REG_START_TAN_Y = 4'd5,
		REG_END_TAN_X   = 4'd6,
		REG_END_TAN_Y   = 4'd7
	} chpe_reg_t;

	typedef struct packed {
		logic signed [PARAM_WIDTH-1:0] param_t;
		logic signed [COORD_WIDTH-1:0] offset_x;
		logic signed [COORD_WIDTH-1:0] offset_y;
	} chpe_in_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
	} chpe_out_t;

	// Per-stage load enables, driven by the pipeline control in the top level
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
		logic en_s6;
	} chpe_stage_en_t;

	typedef struct packed {
		logic [WGT_W-1:0] w_a;
		logic [WGT_W-1:0] w_d;
		logic [WGT_W-1:0] w_u;
		logic [WGT_W-1:0] w_v;
	} chpe_weights_t;

endpackage

// ===== src/chpe_weights.sv =====
`timescale 1ns / 1ps
// Basis weight pipeline: t fraction in, four Hermite weights out after stage 3.
// Depends on chpe_pkg.
module chpe_weights import chpe_pkg::*; (
	input  logic                   clk,
	input  chpe_stage_en_t         ctl,
	input  logic [T_FRAC_BITS-1:0] t_frac,
	output chpe_weights_t          weights
);

	logic [T_FRAC_BITS-1:0] t_s1, t_s2;
	logic [T_W-1:0]         s_s1, s_s2;
	logic [T_W-1:0]         s2_s2, t2_s2;
	chpe_weights_t          w_s3;

	logic [WPROD_W-1:0] ss_prod, tt_prod;
	logic [WGT_W-1:0]   lin_a, lin_d;
	logic [WPROD_W-1:0] pa, pd, pu, pv;

	always_comb begin
		ss_prod = WPROD_W'(s_s1) * WPROD_W'(s_s1) + W_HALF;
		tt_prod = WPROD_W'(t_s1) * WPROD_W'(t_s1) + W_HALF;
		// 1 + 2t and 1 + 2s
		lin_a = WGT_W'(T_ONE) + {1'b0, t_s2, 1'b0};
		lin_d = WGT_W'(T_ONE) + {s_s2, 1'b0};
		pa = WPROD_W'(s2_s2) * WPROD_W'(lin_a) + W_HALF;
		pd = WPROD_W'(t2_s2) * WPROD_W'(lin_d) + W_HALF;
		pu = WPROD_W'(s2_s2) * WPROD_W'(t_s2) + W_HALF;
		pv = WPROD_W'(t2_s2) * WPROD_W'(s_s2) + W_HALF;
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			t_s1 <= t_frac;
			s_s1 <= T_ONE - T_W'(t_frac);
		end
		if (ctl.en_s2) begin
			t_s2  <= t_s1;
			s_s2  <= s_s1;
			s2_s2 <= ss_prod[T_FRAC_BITS +: T_W];
			t2_s2 <= tt_prod[T_FRAC_BITS +: T_W];
		end
		if (ctl.en_s3) begin
			w_s3.w_a <= pa[T_FRAC_BITS +: WGT_W];
			w_s3.w_d <= pd[T_FRAC_BITS +: WGT_W];
			w_s3.w_u <= pu[T_FRAC_BITS +: WGT_W];
			w_s3.w_v <= pv[T_FRAC_BITS +: WGT_W];
		end
	end

	assign weights = w_s3;

endmodule

// ===== src/chpe_axis.sv =====
`timescale 1ns / 1ps
// One coordinate axis: offset positions, weighted products, exact sum,
// round half up and saturate. Depends on chpe_pkg.
module chpe_axis import chpe_pkg::*; (
	input  logic                          clk,
	input  chpe_stage_en_t                ctl,
	input  logic signed [COORD_WIDTH-1:0] pos_start,
	input  logic signed [COORD_WIDTH-1:0] pos_end,
	input  logic signed [COORD_WIDTH-1:0] tan_start,
	input  logic signed [COORD_WIDTH-1:0] tan_end,
	input  logic signed [COORD_WIDTH-1:0] offset,
	input  chpe_weights_t                 weights,
	output logic signed [COORD_WIDTH-1:0] point
);

	logic signed [POS_W-1:0]       a_s1, a_s2, a_s3;
	logic signed [POS_W-1:0]       d_s1, d_s2, d_s3;
	logic signed [PROD_W-1:0]      pa_s4, pd_s4, pu_s4, pv_s4;
	logic signed [SUM_W-1:0]       sum_s5;
	logic signed [COORD_WIDTH-1:0] point_s6;

	logic signed [PROD_W-1:0] pa, pd, pu, pv;
	logic signed [SUM_W-1:0]  rounded;

	always_comb begin
		// weights are unsigned: widen with a zero sign bit
		pa = PROD_W'(a_s3) * PROD_W'($signed({1'b0, weights.w_a}));
		pd = PROD_W'(d_s3) * PROD_W'($signed({1'b0, weights.w_d}));
		pu = PROD_W'(tan_start) * PROD_W'($signed({1'b0, weights.w_u}));
		pv = PROD_W'(tan_end) * PROD_W'($signed({1'b0, weights.w_v}));
		rounded = (sum_s5 + SUM_HALF) >>> T_FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			a_s1 <= POS_W'(pos_start) + POS_W'(offset);
			d_s1 <= POS_W'(pos_end) + POS_W'(offset);
		end
		if (ctl.en_s2) begin
			a_s2 <= a_s1;
			d_s2 <= d_s1;
		end
		if (ctl.en_s3) begin
			a_s3 <= a_s2;
			d_s3 <= d_s2;
		end
		if (ctl.en_s4) begin
			pa_s4 <= pa;
			pd_s4 <= pd;
			pu_s4 <= pu;
			pv_s4 <= pv;
		end
		if (ctl.en_s5)
			sum_s5 <= SUM_W'(pa_s4) + SUM_W'(pd_s4) + SUM_W'(pu_s4) - SUM_W'(pv_s4);
		if (ctl.en_s6) begin
			if (rounded > SAT_MAX)
				point_s6 <= SAT_MAX[COORD_WIDTH-1:0];
			else if (rounded < SAT_MIN)
				point_s6 <= SAT_MIN[COORD_WIDTH-1:0];
			else
				point_s6 <= rounded[COORD_WIDTH-1:0];
		end
	end

	assign point = point_s6;

endmodule

// ===== src/cubic_hermite_point_eval.sv =====
`timescale 1ns / 1ps
// Cubic Hermite point evaluator, top level: segment registers, pipeline control.
// Pipeline: stages s1..s6 from input beat to result beat, s6 is the output register.
// Throughput: one point per cycle while out_ready is high; a stage refills as soon as the one after it moves on.
// Reset: arst_n clears stage valid bits and the segment registers to zero.
// Depends on chpe_pkg, chpe_weights, chpe_axis.
module cubic_hermite_point_eval import chpe_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  chpe_in_t               in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output chpe_out_t              out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data
);

	logic signed [COORD_WIDTH-1:0] start_pos_x_q, start_pos_y_q, end_pos_x_q, end_pos_y_q;
	logic signed [COORD_WIDTH-1:0] start_tan_x_q, start_tan_y_q, end_tan_x_q, end_tan_y_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	chpe_stage_en_t ctl;
	chpe_weights_t  weights;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pos_x_q <= '0;
			start_pos_y_q <= '0;
			end_pos_x_q   <= '0;
			end_pos_y_q   <= '0;
			start_tan_x_q <= '0;
			start_tan_y_q <= '0;
			end_tan_x_q   <= '0;
			end_tan_y_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_START_POS_X: start_pos_x_q <= cfg_data;
				REG_START_POS_Y: start_pos_y_q <= cfg_data;
				REG_END_POS_X:   end_pos_x_q   <= cfg_data;
				REG_END_POS_Y:   end_pos_y_q   <= cfg_data;
				REG_START_TAN_X: start_tan_x_q <= cfg_data;
				REG_START_TAN_Y: start_tan_y_q <= cfg_data;
				REG_END_TAN_X:   end_tan_x_q   <= cfg_data;
				REG_END_TAN_Y:   end_tan_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or its contents move on this cycle
	always_comb begin
		ctl.en_s6 = !v_s6 || out_ready;
		ctl.en_s5 = !v_s5 || ctl.en_s6;
		ctl.en_s4 = !v_s4 || ctl.en_s5;
		ctl.en_s3 = !v_s3 || ctl.en_s4;
		ctl.en_s2 = !v_s2 || ctl.en_s3;
		ctl.en_s1 = !v_s1 || ctl.en_s2;
	end

	assign in_ready  = ctl.en_s1;
	assign out_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ctl.en_s1) v_s1 <= in_valid;
			if (ctl.en_s2) v_s2 <= v_s1;
			if (ctl.en_s3) v_s3 <= v_s2;
			if (ctl.en_s4) v_s4 <= v_s3;
			if (ctl.en_s5) v_s5 <= v_s4;
			if (ctl.en_s6) v_s6 <= v_s5;
		end
	end

	chpe_weights u_weights (
		.clk     (clk),
		.ctl     (ctl),
		.t_frac  (in_data.param_t[T_FRAC_BITS-1:0]),
		.weights (weights)
	);

	chpe_axis u_axis_x (
		.clk       (clk),
		.ctl       (ctl),
		.pos_start (start_pos_x_q),
		.pos_end   (end_pos_x_q),
		.tan_start (start_tan_x_q),
		.tan_end   (end_tan_x_q),
		.offset    (in_data.offset_x),
		.weights   (weights),
		.point     (out_data.point_x)
	);

	chpe_axis u_axis_y (
		.clk       (clk),
		.ctl       (ctl),
		.pos_start (start_pos_y_q),
		.pos_end   (end_pos_y_q),
		.tan_start (start_tan_y_q),
		.tan_end   (end_tan_y_q),
		.offset    (in_data.offset_y),
		.weights   (weights),
		.point     (out_data.point_y)
	);

endmodule
